// File: rtl/vt4_pkg.sv
// Package with the payload types, register map and fixed constants of the vertex transform.
package vt4_pkg;

	// Fixed field widths.
	localparam int unsigned FIELD_W   = 32;
	localparam int unsigned COEF_W    = 32;
	localparam int unsigned CFG_W     = 64;
	localparam int unsigned FRAC_W    = 16;
	localparam int unsigned NUM_DIM   = 4;
	localparam int unsigned NUM_CFG   = 8;
	localparam int unsigned CFG_IDX_W = 4;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_ROW0_COLS01 = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROW0_COLS23 = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ROW1_COLS01 = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ROW1_COLS23 = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ROW2_COLS01 = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ROW2_COLS23 = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_ROW3_COLS01 = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_ROW3_COLS23 = 4'd7;

	typedef logic [NUM_CFG-1:0][CFG_W-1:0]              cfg_bank_t;
	typedef logic [NUM_DIM-1:0][COEF_W-1:0]             mat_row_t;
	typedef logic [NUM_DIM-1:0][NUM_DIM-1:0][COEF_W-1:0] matrix_t;

	// Identity matrix: ones on the diagonal in Q16.16.
	localparam cfg_bank_t CFG_RESET = {
		64'h0001_0000_0000_0000,
		64'h0000_0000_0000_0000,
		64'h0000_0000_0001_0000,
		64'h0000_0000_0000_0000,
		64'h0000_0000_0000_0000,
		64'h0001_0000_0000_0000,
		64'h0000_0000_0000_0000,
		64'h0000_0000_0001_0000
	};

	// Vertex transaction.
	typedef struct packed {
		logic signed [FIELD_W-1:0] in_x;
		logic signed [FIELD_W-1:0] in_y;
		logic signed [FIELD_W-1:0] in_z;
		logic signed [FIELD_W-1:0] in_w;
	} vtx_t;

	// Result transaction.
	typedef struct packed {
		logic signed [FIELD_W-1:0] out_x;
		logic signed [FIELD_W-1:0] out_y;
		logic signed [FIELD_W-1:0] out_z;
		logic signed [FIELD_W-1:0] out_w;
		logic                      clipped;
	} res_t;

	// Load enables of the four pipeline stages.
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
	} pipe_en_t;

endpackage

// File: rtl/vertex_transform_4x4.sv
// Top level of the 4x4 vertex transform: configuration, four row datapaths and pipeline control.
//
//  Channel  Signals                              Moves
//  -------  -----------------------------------  -------------------------------------
//  vtx      vtx_valid, vtx_stall, vtx_data       one vertex (x, y, z, w) per transaction
//  res      res_valid, res_stall, res_data       transformed vertex and clipped flag
//  cfg      cfg_valid, cfg_ready, cfg_index,     one 64-bit coefficient register write
//           cfg_data
//
// One vertex enters per clock while vtx_stall is low; each result passes in order through the
// multiply, pair-sum, sum-and-round and saturate stages. The sixteen 32-bit multipliers
// of the first stage set the clock.
// Reset loads the identity matrix and empties the pipeline.
// A stall on the result side holds only the stages that are full; bubbles close up, and
// vtx_stall rises once all four stages hold a transaction.
module vertex_transform_4x4
	import vt4_pkg::*;
#(
	parameter int unsigned COORD_WIDTH = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 vtx_valid,
	output logic                 vtx_stall,
	input  vtx_t                 vtx_data,
	output logic                 res_valid,
	input  logic                 res_stall,
	output res_t                 res_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	matrix_t                                 matrix;
	logic [NUM_DIM-1:0][COORD_WIDTH-1:0]     crd;
	logic [NUM_DIM-1:0][FIELD_W-1:0]         row_val;
	logic [NUM_DIM-1:0]                      row_sat;
	pipe_en_t                                en;
	logic                                    valid_s1;
	logic                                    valid_s2;
	logic                                    valid_s3;
	logic                                    valid_s4;

	// Coefficient registers; writes are always taken.
	assign cfg_ready = 1'b1;

	vt4_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.matrix   (matrix)
	);

	// Only the low COORD_WIDTH bits of each coordinate count.
	assign crd[0] = vtx_data.in_x[COORD_WIDTH-1:0];
	assign crd[1] = vtx_data.in_y[COORD_WIDTH-1:0];
	assign crd[2] = vtx_data.in_z[COORD_WIDTH-1:0];
	assign crd[3] = vtx_data.in_w[COORD_WIDTH-1:0];

	// A stage loads when it is empty or the stage after it moves on.
	assign en.s4     = !valid_s4 || !res_stall;
	assign en.s3     = !valid_s3 || en.s4;
	assign en.s2     = !valid_s2 || en.s3;
	assign en.s1     = !valid_s1 || en.s2;
	assign vtx_stall = !en.s1;

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (en.s1) valid_s1 <= vtx_valid;
			if (en.s2) valid_s2 <= valid_s1;
			if (en.s3) valid_s3 <= valid_s2;
			if (en.s4) valid_s4 <= valid_s3;
		end
	end

	// One datapath per matrix row.
	for (genvar r = 0; r < NUM_DIM; r++) begin : g_row
		vt4_row #(
			.COORD_WIDTH (COORD_WIDTH)
		) u_row (
			.clk  (clk),
			.en   (en),
			.coef (matrix[r]),
			.crd  (crd),
			.val  (row_val[r]),
			.sat  (row_sat[r])
		);
	end

	// Result transaction.
	assign res_valid        = valid_s4;
	assign res_data.out_x   = row_val[0];
	assign res_data.out_y   = row_val[1];
	assign res_data.out_z   = row_val[2];
	assign res_data.out_w   = row_val[3];
	assign res_data.clipped = |row_sat;

`ifndef SYNTHESIS
	// The input side stalls only when every stage is full and the output is held.
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		vtx_stall |-> (valid_s1 && valid_s2 && valid_s3 && valid_s4 && res_stall))
		else $error("vtx_stall raised with room in the pipeline");

	// An accepted vertex occupies the first stage on the next cycle.
	a_accept_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(vtx_valid && !vtx_stall) |=> valid_s1)
		else $error("accepted vertex did not enter stage 1");

	// A write to the first register lands in row 0, columns 0 and 1.
	a_cfg_row0: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && cfg_ready && cfg_index == REG_ROW0_COLS01) |=>
		({matrix[0][1], matrix[0][0]} == $past(cfg_data)))
		else $error("row 0 coefficient write lost");
`endif

endmodule

// File: rtl/vt4_cfg.sv
// Matrix coefficient registers and their write port.
module vt4_cfg
	import vt4_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [CFG_IDX_W-1:0] wr_index,
	input  logic [CFG_W-1:0]     wr_data,
	output matrix_t              matrix
);

	cfg_bank_t regs_q;

	// Register writes; an index beyond the map is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q <= CFG_RESET;
		end else if (wr_en) begin
			for (int i = 0; i < NUM_CFG; i++) begin
				if (wr_index == CFG_IDX_W'(i)) begin
					regs_q[i] <= wr_data;
				end
			end
		end
	end

	// Each register holds an even column in its low half and the odd column in its high half.
	always_comb begin
		for (int r = 0; r < NUM_DIM; r++) begin
			for (int c = 0; c < NUM_DIM; c++) begin
				matrix[r][c] = regs_q[r * 2 + c / 2][(c % 2) * COEF_W +: COEF_W];
			end
		end
	end

endmodule

// File: rtl/vt4_row.sv
// Datapath of one matrix row: multiply, add tree, rounding and saturation over four stages.
module vt4_row
	import vt4_pkg::*;
#(
	parameter int unsigned COORD_WIDTH = 32
) (
	input  logic                             clk,
	input  pipe_en_t                         en,
	input  mat_row_t                         coef,
	input  logic [NUM_DIM-1:0][COORD_WIDTH-1:0] crd,
	output logic [FIELD_W-1:0]               val,
	output logic                             sat
);

	localparam int unsigned PROD_W = COEF_W + COORD_WIDTH;
	localparam int unsigned SUM2_W = PROD_W + 1;
	localparam int unsigned SUM4_W = PROD_W + 2;
	localparam int unsigned RND_W  = SUM4_W - FRAC_W;
	localparam int unsigned HI_W   = RND_W - COORD_WIDTH + 1;
	localparam logic signed [SUM4_W-1:0] RND_BIAS = SUM4_W'(1) << (FRAC_W - 1);
	localparam logic [COORD_WIDTH-1:0] MAX_VAL = {1'b0, {(COORD_WIDTH - 1){1'b1}}};
	localparam logic [COORD_WIDTH-1:0] MIN_VAL = {1'b1, {(COORD_WIDTH - 1){1'b0}}};

	logic signed [PROD_W-1:0] prod_d  [NUM_DIM];
	logic signed [PROD_W-1:0] prod_s1 [NUM_DIM];
	logic signed [SUM2_W-1:0] pair_s2 [2];
	logic signed [SUM4_W-1:0] sum_d;
	logic signed [RND_W-1:0]  rnd_s3;
	logic [HI_W-1:0]          hi_bits;
	logic                     in_range;
	logic [COORD_WIDTH-1:0]   sat_val;
	logic [FIELD_W-1:0]       val_s4;
	logic                     sat_s4;

	// Stage 1: the four coefficient-coordinate products.
	always_comb begin
		for (int c = 0; c < NUM_DIM; c++) begin
			prod_d[c] = $signed(coef[c]) * $signed(crd[c]);
		end
	end

	always_ff @(posedge clk) begin
		if (en.s1) begin
			prod_s1 <= prod_d;
		end
	end

	// Stage 2: pairwise sums.
	always_ff @(posedge clk) begin
		if (en.s2) begin
			pair_s2[0] <= SUM2_W'(prod_s1[0]) + SUM2_W'(prod_s1[1]);
			pair_s2[1] <= SUM2_W'(prod_s1[2]) + SUM2_W'(prod_s1[3]);
		end
	end

	// Stage 3: full-width sum, round half up, drop the fraction bits.
	assign sum_d = SUM4_W'(pair_s2[0]) + SUM4_W'(pair_s2[1]) + RND_BIAS;

	always_ff @(posedge clk) begin
		if (en.s3) begin
			rnd_s3 <= sum_d[SUM4_W-1:FRAC_W];
		end
	end

	// Stage 4: saturate when the upper bits are not a plain sign extension.
	assign hi_bits  = rnd_s3[RND_W-1:COORD_WIDTH-1];
	assign in_range = (&hi_bits) || !(|hi_bits);

	always_comb begin
		if (in_range) begin
			sat_val = rnd_s3[COORD_WIDTH-1:0];
		end else if (rnd_s3[RND_W-1]) begin
			sat_val = MIN_VAL;
		end else begin
			sat_val = MAX_VAL;
		end
	end

	always_ff @(posedge clk) begin
		if (en.s4) begin
			val_s4 <= FIELD_W'($signed(sat_val));
			sat_s4 <= !in_range;
		end
	end

	assign val = val_s4;
	assign sat = sat_s4;

endmodule

// File: bench/tb.sv
// Self-checking testbench for the 4x4 Q16.16 vertex transform.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import vt4_pkg::*;

	localparam int unsigned COORD_W = 32;
	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned PHASES = 8;
	localparam int unsigned VERTICES_PER_PHASE = 125;
	localparam int unsigned STEADY_PHASE = 5;
	localparam int unsigned IDLE_PERCENT = 36;

	localparam logic signed [31:0] QMAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] QMIN = 32'sh8000_0000;
	localparam logic signed [31:0] QONE = 32'sh0001_0000;
	localparam logic signed [31:0] QHALF_LSB = 32'sh0000_8000;
	localparam logic signed [31:0] QLSB = 32'sh0000_0001;

	// Register indexes past the end of the bank; writes to them must be dropped.
	localparam logic [CFG_IDX_W-1:0] REG_NONE_LO = CFG_IDX_W'(NUM_CFG);
	localparam logic [CFG_IDX_W-1:0] REG_NONE_HI = '1;

	// How widely a random coordinate or coefficient is spread.
	typedef enum int unsigned {
		SPREAD_TYPICAL,
		SPREAD_FULL,
		SPREAD_EXTREME,
		SPREAD_MIXED
	} spread_e;

	// One row of the directed plan: either a register write or a vertex.
	typedef struct {
		bit                   is_write;
		logic [CFG_IDX_W-1:0] idx;
		logic [CFG_W-1:0]     word;
		vtx_t                 vertex;
		bit                   typed;
		res_t                 want;
	} plan_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 vtx_valid = 1'b0;
	logic                 vtx_stall;
	vtx_t                 vtx_data = '0;
	logic                 res_valid;
	logic                 res_stall = 1'b0;
	res_t                 res_data;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;

	logic [CFG_W-1:0] coef_regs [NUM_CFG];
	res_t             predicted_out [$];
	plan_row_t        plan [$];
	bit               steady = 1'b0;
	int unsigned      mismatch_count = 0;
	int unsigned      results_seen = 0;
	int unsigned      cycle_count = 0;

	vertex_transform_4x4 #(.COORD_WIDTH(COORD_W)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.vtx_valid (vtx_valid),
		.vtx_stall (vtx_stall),
		.vtx_data  (vtx_data),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Matrix times vertex: exact wide sum, round half up, shift back, saturate.
	function automatic res_t transform_vertex(input vtx_t v);
		logic signed [31:0] coord [NUM_DIM];
		logic signed [31:0] coef;
		logic signed [67:0] acc;
		logic signed [67:0] top;
		logic signed [67:0] bottom;
		logic [CFG_W-1:0]   word;
		logic [31:0]        row_out [NUM_DIM];
		bit                 clip;
		res_t               r;
		coord[0] = v.in_x;
		coord[1] = v.in_y;
		coord[2] = v.in_z;
		coord[3] = v.in_w;
		clip = 1'b0;
		top = (68'sd1 <<< (COORD_W - 1)) - 68'sd1;
		bottom = -top - 68'sd1;
		// Only the low COORD_W bits of a coordinate count.
		for (int i = 0; i < NUM_DIM; i++)
			coord[i] = (coord[i] <<< (FIELD_W - COORD_W)) >>> (FIELD_W - COORD_W);
		for (int row = 0; row < NUM_DIM; row++) begin
			acc = '0;
			for (int col = 0; col < NUM_DIM; col++) begin
				word = coef_regs[row * 2 + col / 2];
				coef = (col % 2) ? word[63:32] : word[31:0];
				acc = acc + coef * coord[col];
			end
			acc = (acc + 68'sd32768) >>> FRAC_W;
			if (acc > top) begin
				acc = top;
				clip = 1'b1;
			end
			if (acc < bottom) begin
				acc = bottom;
				clip = 1'b1;
			end
			row_out[row] = acc[31:0];
		end
		r.out_x = row_out[0];
		r.out_y = row_out[1];
		r.out_z = row_out[2];
		r.out_w = row_out[3];
		r.clipped = clip;
		return r;
	endfunction

	function automatic logic [31:0] random_value(input spread_e spread, input bit is_coef);
		spread_e pick;
		pick = spread;
		if (pick == SPREAD_MIXED)
			pick = spread_e'($urandom_range(SPREAD_TYPICAL, SPREAD_EXTREME));
		case (pick)
			SPREAD_TYPICAL: begin
				// Coefficients within +-4.0, coordinates within +-1024.0.
				if (is_coef)
					return 32'($urandom_range(0, 1 << 19)) - 32'(1 << 18);
				return 32'($urandom_range(0, 1 << 27)) - 32'(1 << 26);
			end
			SPREAD_FULL: return $urandom;
			default: begin
				case ($urandom_range(0, 6))
					0: return QMAX;
					1: return QMIN;
					2: return '0;
					3: return QONE;
					4: return -QONE;
					5: return QHALF_LSB;
					default: return QLSB;
				endcase
			end
		endcase
	endfunction

	function automatic vtx_t random_vertex();
		spread_e spread;
		vtx_t v;
		case ($urandom_range(0, 3))
			0, 1: spread = SPREAD_TYPICAL;
			2: spread = SPREAD_FULL;
			default: spread = SPREAD_EXTREME;
		endcase
		v.in_x = random_value(spread, 1'b0);
		v.in_y = random_value(spread, 1'b0);
		v.in_z = random_value(spread, 1'b0);
		v.in_w = random_value(spread, 1'b0);
		return v;
	endfunction

	function automatic void add_write(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_W-1:0] word);
		plan_row_t row;
		row = '{is_write: 1'b1, idx: idx, word: word, vertex: '0, typed: 1'b0, want: '0};
		plan.push_back(row);
	endfunction

	function automatic void add_vertex(input vtx_t v, input bit typed, input res_t want);
		plan_row_t row;
		row = '{is_write: 1'b0, idx: '0, word: '0, vertex: v, typed: typed, want: want};
		plan.push_back(row);
	endfunction

	function automatic void add_uniform_matrix(input logic [31:0] coef);
		for (int r = 0; r < NUM_CFG; r++)
			add_write(CFG_IDX_W'(r), {coef, coef});
	endfunction

	// Prints one line per mismatch and keeps the count.
	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("tb: mismatch in %s at result %0d: got %h, expected %h",
			what, results_seen, got, want);
		mismatch_count++;
	endtask

	// Writes one coefficient register once every awaited result has come back.
	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_W-1:0] word);
		vtx_valid <= 1'b0;
		while (predicted_out.size() != 0)
			@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= word;
		do
			@(posedge clk);
		while (!cfg_ready);
		if (idx < NUM_CFG)
			coef_regs[idx] = word;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Offers one vertex transaction, with random idle cycles ahead of it.
	task automatic send_vertex(input vtx_t v, input bit typed, input res_t want);
		while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
			vtx_valid <= 1'b0;
			@(posedge clk);
		end
		vtx_valid <= 1'b1;
		vtx_data <= v;
		do
			@(posedge clk);
		while (vtx_stall);
		predicted_out.push_back(typed ? want : transform_vertex(v));
	endtask

	// Result side stalls at random, except through the steady phase.
	always @(posedge clk)
		res_stall <= !steady && ($urandom_range(0, 99) < IDLE_PERCENT);

	// Each result transaction is matched with the oldest prediction.
	always @(posedge clk) begin
		res_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (predicted_out.size() == 0) begin
				report_mismatch("result with nothing awaited", res_data.out_x, 'x);
			end else begin
				want = predicted_out.pop_front();
				if (res_data.out_x !== want.out_x)
					report_mismatch("out_x", res_data.out_x, want.out_x);
				if (res_data.out_y !== want.out_y)
					report_mismatch("out_y", res_data.out_y, want.out_y);
				if (res_data.out_z !== want.out_z)
					report_mismatch("out_z", res_data.out_z, want.out_z);
				if (res_data.out_w !== want.out_w)
					report_mismatch("out_w", res_data.out_w, want.out_w);
				if (res_data.clipped !== want.clipped)
					report_mismatch("clipped", 32'(res_data.clipped), 32'(want.clipped));
			end
			results_seen++;
		end
	end

	// Watchdog on the total run length.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb: failure");
		$finish;
	end

	initial begin
		vtx_t v;
		logic [CFG_W-1:0] word;
		spread_e spread;

		// Identity after reset: every vertex comes back unchanged.
		add_vertex('0, 1'b1, '0);
		add_vertex({QMAX, QMIN, QONE, -QONE}, 1'b1, {QMAX, QMIN, QONE, -QONE, 1'b0});
		add_vertex({QMIN, QMAX, -QONE, QONE}, 1'b1, {QMIN, QMAX, -QONE, QONE, 1'b0});
		add_vertex({32'h1234_5678, 32'hFEDC_BA98, 32'h0000_8000, 32'hFFFF_7FFF}, 1'b1,
			{32'h1234_5678, 32'hFEDC_BA98, 32'h0000_8000, 32'hFFFF_7FFF, 1'b0});
		// Largest positive coefficients: overflow both ways saturates.
		add_uniform_matrix(QMAX);
		add_vertex({QMAX, QMAX, QMAX, QMAX}, 1'b1, {QMAX, QMAX, QMAX, QMAX, 1'b1});
		add_vertex({QMIN, QMIN, QMIN, QMIN}, 1'b1, {QMIN, QMIN, QMIN, QMIN, 1'b1});
		add_vertex('0, 1'b1, '0);
		// Most negative coefficients: the full 66-bit sum must not wrap.
		add_uniform_matrix(QMIN);
		add_vertex({QMIN, QMIN, QMIN, QMIN}, 1'b1, {QMAX, QMAX, QMAX, QMAX, 1'b1});
		add_vertex({QMAX, QMAX, QMAX, QMAX}, 1'b1, {QMIN, QMIN, QMIN, QMIN, 1'b1});
		add_vertex({QMIN, QMAX, QMIN, QMAX}, 1'b0, '0);
		// Smallest coefficient: rounding of ties and near-ties.
		add_uniform_matrix(QLSB);
		add_vertex({QHALF_LSB, 32'h0, 32'h0, 32'h0}, 1'b1, {QLSB, QLSB, QLSB, QLSB, 1'b0});
		add_vertex({-QHALF_LSB, 32'h0, 32'h0, 32'h0}, 1'b1, '0);
		add_vertex({QHALF_LSB - QLSB, 32'h0, 32'h0, 32'h0}, 1'b0, '0);
		add_vertex({-QHALF_LSB - QONE, 32'h0, 32'h0, 32'h0}, 1'b0, '0);
		add_vertex({QMAX, QMAX, QMAX, QMAX}, 1'b0, '0);
		// Writes past the end of the bank leave the matrix alone.
		add_write(REG_NONE_LO, {QMAX, QMAX});
		add_write(REG_NONE_HI, {QMIN, QMIN});
		add_vertex({QHALF_LSB, 32'h0, 32'h0, 32'h0}, 1'b1, {QLSB, QLSB, QLSB, QLSB, 1'b0});
		// Distinct coefficients everywhere, probed with unit vectors.
		for (int r = 0; r < NUM_CFG; r++)
			add_write(CFG_IDX_W'(r), {32'(QONE * (2 * r + 2)), 32'(-QONE * (2 * r + 1))});
		add_vertex({QONE, 32'h0, 32'h0, 32'h0}, 1'b0, '0);
		add_vertex({32'h0, QONE, 32'h0, 32'h0}, 1'b0, '0);
		add_vertex({32'h0, 32'h0, QONE, 32'h0}, 1'b0, '0);
		add_vertex({32'h0, 32'h0, 32'h0, QONE}, 1'b0, '0);

		for (int r = 0; r < NUM_CFG; r++)
			coef_regs[r] = CFG_RESET[r];

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed plan.
		foreach (plan[i]) begin
			if (plan[i].is_write)
				write_register(plan[i].idx, plan[i].word);
			else
				send_vertex(plan[i].vertex, plan[i].typed, plan[i].want);
		end

		// Random phases, each with a fresh matrix.
		for (int phase = 0; phase < PHASES; phase++) begin
			spread = spread_e'(phase % 4);
			for (int r = 0; r < NUM_CFG; r++) begin
				word = {random_value(spread, 1'b1), random_value(spread, 1'b1)};
				write_register(CFG_IDX_W'(r), word);
			end
			if ($urandom_range(0, 2) == 0)
				write_register(CFG_IDX_W'($urandom_range(NUM_CFG, 15)), {$urandom, $urandom});
			steady = (phase == STEADY_PHASE);
			for (int n = 0; n < VERTICES_PER_PHASE; n++) begin
				v = random_vertex();
				send_vertex(v, 1'b0, '0);
			end
			steady = 1'b0;
		end

		vtx_valid <= 1'b0;
		while (predicted_out.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatch_count == 0 && predicted_out.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// File: files.f
rtl/vt4_pkg.sv
rtl/vt4_cfg.sv
rtl/vt4_row.sv
rtl/vertex_transform_4x4.sv
bench/tb.sv
